[hdl/dscr_pkg.sv]
// Shared types and constants for the disk sector chain reader.
// No dependencies; imported by every module of the block.
package dscr_pkg;

    localparam int SEC_BYTES = 256;
    localparam int D81_SPT = 40;

    localparam int D64_ZONE1_LAST = 17;
    localparam int D64_ZONE2_LAST = 24;
    localparam int D64_ZONE3_LAST = 30;
    localparam int D64_ZONE1_SPT = 21;
    localparam int D64_ZONE2_SPT = 19;
    localparam int D64_ZONE3_SPT = 18;
    localparam int D64_ZONE4_SPT = 17;
    localparam int D64_ZONE2_BASE = 32'h16500 / SEC_BYTES;
    localparam int D64_ZONE3_BASE = 32'h1EA00 / SEC_BYTES;
    localparam int D64_ZONE4_BASE = 32'h25600 / SEC_BYTES;

    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    localparam logic [1:0] REG_IMAGE_IS_D81  = 2'd0;
    localparam logic [1:0] REG_TRACK_LIMIT   = 2'd1;
    localparam logic [1:0] REG_IMAGE_SIZE    = 2'd2;
    localparam logic [1:0] REG_OUT_CAPACITY  = 2'd3;

    typedef enum logic [1:0] {
        KIND_FETCH = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_ERROR = 2'd3
    } t_kind;

    typedef struct packed {
        logic        is_d81;
        logic [6:0]  track_limit;
        logic [19:0] image_size;
        logic [23:0] capacity;
    } t_cfg;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [19:0] offset;
        logic [7:0]  data;
        logic [23:0] count;
    } t_result;

endpackage

[hdl/dscr_locate.sv]
// Sector check and byte offset for one track/sector pair.
// Depends on dscr_pkg for geometry constants and the configuration struct.
module dscr_locate
    import dscr_pkg::*;
#(
    parameter int ZONE_TABLE_TRACKS = 40
) (
    input  t_cfg        i_cfg,
    input  logic [7:0]  i_track,
    input  logic [7:0]  i_sector,
    output logic        o_ok,
    output logic [19:0] o_offset
);

    logic [5:0]  zone_spt;
    logic [13:0] zone_base;
    logic [7:0]  zone_first;
    logic [7:0]  rel_track;
    logic [5:0]  spt;
    logic [13:0] d64_idx;
    logic [13:0] d81_idx;
    logic [13:0] idx;
    logic [22:0] end_byte;
    logic        track_ok;

    always_comb begin
        priority if (i_track <= 8'(D64_ZONE1_LAST)) begin
            zone_spt   = 6'(D64_ZONE1_SPT);
            zone_base  = 14'd0;
            zone_first = 8'd1;
        end else if (i_track <= 8'(D64_ZONE2_LAST)) begin
            zone_spt   = 6'(D64_ZONE2_SPT);
            zone_base  = 14'(D64_ZONE2_BASE);
            zone_first = 8'(D64_ZONE1_LAST + 1);
        end else if (i_track <= 8'(D64_ZONE3_LAST)) begin
            zone_spt   = 6'(D64_ZONE3_SPT);
            zone_base  = 14'(D64_ZONE3_BASE);
            zone_first = 8'(D64_ZONE2_LAST + 1);
        end else begin
            zone_spt   = 6'(D64_ZONE4_SPT);
            zone_base  = 14'(D64_ZONE4_BASE);
            zone_first = 8'(D64_ZONE3_LAST + 1);
        end
    end

    assign rel_track = i_track - zone_first;
    assign d64_idx   = zone_base + 14'(rel_track) * 14'(zone_spt) + 14'(i_sector);
    assign d81_idx   = 14'(i_track - 8'd1) * 14'(D81_SPT) + 14'(i_sector);
    assign idx       = i_cfg.is_d81 ? d81_idx : d64_idx;
    assign spt       = i_cfg.is_d81 ? 6'(D81_SPT) : zone_spt;
    assign end_byte  = {15'(idx) + 15'd1, 8'h00};

    assign track_ok = (i_track != 8'd0) && (i_track <= {1'b0, i_cfg.track_limit})
                    && (i_cfg.is_d81 || (i_track <= 8'(ZONE_TABLE_TRACKS)));

    assign o_ok = track_ok && (i_sector < {2'b00, spt})
                && (end_byte <= {3'b000, i_cfg.image_size});
    assign o_offset = {idx[11:0], 8'h00};

endmodule

[hdl/dscr_core.sv]
// Chain state and per-item decision: link capture, checks, data and done.
// Depends on dscr_pkg and instantiates dscr_locate.
module dscr_core
    import dscr_pkg::*;
#(
    parameter int ZONE_TABLE_TRACKS = 40
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_fire,
    input  logic       i_opcode,
    input  logic [7:0] i_start_track,
    input  logic [7:0] i_start_sector,
    input  logic [7:0] i_sector_byte,
    output t_result    o_res
);

    logic        r_reading, n_reading;
    logic [7:0]  r_pos, n_pos;
    logic [7:0]  r_link_track, n_link_track;
    logic [7:0]  r_link_sector, n_link_sector;
    logic [23:0] r_emitted, n_emitted;

    logic [7:0]  loc_track;
    logic [7:0]  loc_sector;
    logic        loc_ok;
    logic [19:0] loc_offset;
    logic [7:0]  data_len;
    logic [24:0] need;
    logic [23:0] emitted_inc;

    assign loc_track  = (i_opcode == OP_START) ? i_start_track : r_link_track;
    assign loc_sector = (i_opcode == OP_START) ? i_start_sector : i_sector_byte;

    dscr_locate #(
        .ZONE_TABLE_TRACKS(ZONE_TABLE_TRACKS)
    ) u_locate (
        .i_cfg    (i_cfg),
        .i_track  (loc_track),
        .i_sector (loc_sector),
        .o_ok     (loc_ok),
        .o_offset (loc_offset)
    );

    assign data_len    = (r_link_track == 8'd0) ? (i_sector_byte - 8'd1) : 8'd254;
    assign need        = {1'b0, r_emitted} + 25'(data_len);
    assign emitted_inc = r_emitted + 24'd1;

    always_comb begin
        n_reading     = r_reading;
        n_pos         = r_pos;
        n_link_track  = r_link_track;
        n_link_sector = r_link_sector;
        n_emitted     = r_emitted;
        o_res         = '{valid: 1'b0, kind: KIND_FETCH, offset: 20'd0,
                          data: 8'd0, count: r_emitted};
        if (i_fire) begin
            if (i_opcode == OP_START) begin
                n_reading     = 1'b0;
                n_pos         = 8'd0;
                n_emitted     = 24'd0;
                o_res.valid   = 1'b1;
                o_res.count   = 24'd0;
                if (i_cfg.capacity == 24'd0) begin
                    o_res.kind = KIND_ERROR;
                end else if (i_start_track == 8'd0) begin
                    o_res.kind = KIND_DONE;
                end else if (!loc_ok) begin
                    o_res.kind = KIND_ERROR;
                end else begin
                    n_reading    = 1'b1;
                    o_res.kind   = KIND_FETCH;
                    o_res.offset = loc_offset;
                end
            end else if (r_reading) begin
                n_pos = r_pos + 8'd1;
                if (r_pos == 8'd0) begin
                    n_link_track = i_sector_byte;
                end else if (r_pos == 8'd1) begin
                    n_link_sector = i_sector_byte;
                    if ((r_link_track == 8'd0) && (i_sector_byte <= 8'd1)) begin
                        n_reading   = 1'b0;
                        o_res.valid = 1'b1;
                        o_res.kind  = KIND_DONE;
                    end else if (need > {1'b0, i_cfg.capacity}) begin
                        n_reading   = 1'b0;
                        o_res.valid = 1'b1;
                        o_res.kind  = KIND_ERROR;
                    end else if (r_link_track != 8'd0) begin
                        o_res.valid = 1'b1;
                        if (!loc_ok) begin
                            n_reading  = 1'b0;
                            o_res.kind = KIND_ERROR;
                        end else begin
                            o_res.kind   = KIND_FETCH;
                            o_res.offset = loc_offset;
                        end
                    end
                end else if ((r_link_track != 8'd0) || (r_pos < r_link_sector)) begin
                    n_emitted   = emitted_inc;
                    o_res.valid = 1'b1;
                    o_res.kind  = KIND_DATA;
                    o_res.data  = i_sector_byte;
                    o_res.count = emitted_inc;
                end else if (r_pos == r_link_sector) begin
                    n_emitted   = emitted_inc;
                    n_reading   = 1'b0;
                    o_res.valid = 1'b1;
                    o_res.kind  = KIND_DONE;
                    o_res.data  = i_sector_byte;
                    o_res.count = emitted_inc;
                end else begin
                    n_reading = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reading     <= 1'b0;
            r_pos         <= 8'd0;
            r_link_track  <= 8'd0;
            r_link_sector <= 8'd0;
            r_emitted     <= 24'd0;
        end else begin
            r_reading     <= n_reading;
            r_pos         <= n_pos;
            r_link_track  <= n_link_track;
            r_link_sector <= n_link_sector;
            r_emitted     <= n_emitted;
        end
    end

endmodule

[hdl/disk_sector_chain_reader.sv]
// Disk sector chain reader, a D64/D81 file chain walker: one request in,
// at most one result out per cycle.
// An input request is registered, then decided by dscr_core when it advances,
// and any result it yields is registered in the result register.
// One request is accepted every cycle while the output side keeps up; the
// single input register and the single result register set that rate, and a
// stall on the output holds both. Configuration is written through a plain
// write port and must only change while no request is in flight.
// Depends on dscr_pkg; instantiates dscr_core.
module disk_sector_chain_reader
    import dscr_pkg::*;
#(
    parameter int ZONE_TABLE_TRACKS = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [7:0]  i_start_track,
    input  logic [7:0]  i_start_sector,
    input  logic [7:0]  i_sector_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_result_kind,
    output logic [19:0] o_sector_offset,
    output logic [7:0]  o_data_out,
    output logic [23:0] o_loaded_count
);

    t_cfg        r_cfg;
    logic        r_in_valid;
    logic        r_opcode;
    logic [7:0]  r_start_track;
    logic [7:0]  r_start_sector;
    logic [7:0]  r_sector_byte;
    logic        r_out_valid;
    t_result     r_out;
    t_result     core_res;
    logic        advance;
    logic        in_accept;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.is_d81      <= 1'b0;
            r_cfg.track_limit <= 7'd35;
            r_cfg.image_size  <= 20'd174848;
            r_cfg.capacity    <= 24'd65536;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_IMAGE_IS_D81: r_cfg.is_d81      <= i_cfg_data[0];
                REG_TRACK_LIMIT:  r_cfg.track_limit <= i_cfg_data[6:0];
                REG_IMAGE_SIZE:   r_cfg.image_size  <= i_cfg_data[19:0];
                REG_OUT_CAPACITY: r_cfg.capacity    <= i_cfg_data;
                default:          r_cfg             <= r_cfg;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_opcode       <= i_opcode;
            r_start_track  <= i_start_track;
            r_start_sector <= i_start_sector;
            r_sector_byte  <= i_sector_byte;
        end
    end

    dscr_core #(
        .ZONE_TABLE_TRACKS(ZONE_TABLE_TRACKS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_fire         (advance),
        .i_opcode       (r_opcode),
        .i_start_track  (r_start_track),
        .i_start_sector (r_start_sector),
        .i_sector_byte  (r_sector_byte),
        .o_res          (core_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && core_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && core_res.valid) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_kind   = r_out.kind;
    assign o_sector_offset = r_out.offset;
    assign o_data_out      = r_out.data;
    assign o_loaded_count  = r_out.count;

endmodule

[tb/tb.sv]
// Self-checking testbench for disk_sector_chain_reader: directed chain walks, then random
// D64/D81 chains under several geometry settings, checked against an in-bench chain walker.
// Depends on dscr_pkg and the disk_sector_chain_reader RTL.
`timescale 1ns / 1ps

module tb;
    import dscr_pkg::*;

    localparam int ZONE_TRACKS = 40;

    typedef enum logic [1:0] {
        PIN_FREE,
        PIN_RESULT,
        PIN_SILENT
    } t_pin;

    typedef struct packed {
        t_kind       kind;
        logic [19:0] off;
        logic [7:0]  data;
        logic [23:0] cnt;
    } t_chain_result;

    typedef struct {
        logic          op;
        logic [7:0]    trk;
        logic [7:0]    sec;
        logic [7:0]    byt;
        t_pin          pin;
        t_chain_result want;
    } t_stim_row;

    typedef struct {
        logic        d81;
        logic [6:0]  max_trk;
        logic [19:0] size;
        logic [23:0] cap;
        int          quota;
        bit          quiet;
    } t_geometry;

    localparam t_chain_result NO_WANT = '{KIND_FETCH, 20'd0, 8'd0, 24'd0};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = REG_IMAGE_IS_D81;
    logic [23:0] i_cfg_data = 24'd0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_opcode = OP_START;
    logic [7:0]  i_start_track = 8'd0;
    logic [7:0]  i_start_sector = 8'd0;
    logic [7:0]  i_sector_byte = 8'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_result_kind;
    logic [19:0] o_sector_offset;
    logic [7:0]  o_data_out;
    logic [23:0] o_loaded_count;

    t_pin          pin_mode = PIN_FREE;
    t_chain_result pin_want = NO_WANT;
    bit            calm = 1'b0;

    logic        geo_d81 = 1'b0;
    logic [6:0]  geo_max_trk = 7'd35;
    logic [19:0] geo_size = 20'd174848;
    logic [23:0] geo_cap = 24'd65536;

    logic        walking = 1'b0;
    logic [7:0]  walk_pos = 8'd0;
    logic [7:0]  walk_link_trk = 8'd0;
    logic [7:0]  walk_link_sec = 8'd0;
    logic [23:0] walk_count = 24'd0;

    t_chain_result due_results[$];
    int faults = 0;
    int work_items = 0;
    int item_goal = 0;
    int results_checked = 0;

    t_stim_row script [25] = '{
        '{OP_START, 8'd0,   8'd0,   8'd0,   PIN_RESULT, '{KIND_DONE,  20'd0,      8'd0, 24'd0}},
        '{OP_BYTE,  8'd0,   8'd0,   8'hA5,  PIN_SILENT, NO_WANT},
        '{OP_START, 8'd1,   8'd0,   8'd0,   PIN_RESULT, '{KIND_FETCH, 20'd0,      8'd0, 24'd0}},
        '{OP_BYTE,  8'd0,   8'd0,   8'd0,   PIN_SILENT, NO_WANT},
        '{OP_BYTE,  8'd0,   8'd0,   8'd0,   PIN_RESULT, '{KIND_DONE,  20'd0,      8'd0, 24'd0}},
        '{OP_START, 8'd35,  8'd16,  8'd0,   PIN_RESULT, '{KIND_FETCH, 20'd174592, 8'd0, 24'd0}},
        '{OP_BYTE,  8'd0,   8'd0,   8'd0,   PIN_SILENT, NO_WANT},
        '{OP_BYTE,  8'd0,   8'd0,   8'd1,   PIN_RESULT, '{KIND_DONE,  20'd0,      8'd0, 24'd0}},
        '{OP_START, 8'd36,  8'd0,   8'd0,   PIN_RESULT, '{KIND_ERROR, 20'd0,      8'd0, 24'd0}},
        '{OP_START, 8'd1,   8'd21,  8'd0,   PIN_RESULT, '{KIND_ERROR, 20'd0,      8'd0, 24'd0}},
        '{OP_START, 8'd255, 8'd255, 8'hFF,  PIN_RESULT, '{KIND_ERROR, 20'd0,      8'd0, 24'd0}},
        '{OP_START, 8'd18,  8'd18,  8'd0,   PIN_FREE,   NO_WANT},
        '{OP_BYTE,  8'd0,   8'd0,   8'd0,   PIN_FREE,   NO_WANT},
        '{OP_BYTE,  8'd0,   8'd0,   8'd4,   PIN_FREE,   NO_WANT},
        '{OP_BYTE,  8'd0,   8'd0,   8'hFF,  PIN_FREE,   NO_WANT},
        '{OP_BYTE,  8'd0,   8'd0,   8'h00,  PIN_FREE,   NO_WANT},
        '{OP_BYTE,  8'd0,   8'd0,   8'h5A,  PIN_FREE,   NO_WANT},
        '{OP_BYTE,  8'd0,   8'd0,   8'h33,  PIN_SILENT, NO_WANT},
        '{OP_START, 8'd1,   8'd0,   8'd0,   PIN_RESULT, '{KIND_FETCH, 20'd0,      8'd0, 24'd0}},
        '{OP_BYTE,  8'd0,   8'd0,   8'd36,  PIN_SILENT, NO_WANT},
        '{OP_BYTE,  8'd0,   8'd0,   8'd0,   PIN_RESULT, '{KIND_ERROR, 20'd0,      8'd0, 24'd0}},
        '{OP_START, 8'd17,  8'd20,  8'd0,   PIN_FREE,   NO_WANT},
        '{OP_BYTE,  8'd0,   8'd0,   8'd1,   PIN_FREE,   NO_WANT},
        '{OP_BYTE,  8'd0,   8'd0,   8'd1,   PIN_RESULT, '{KIND_FETCH, 20'd256,    8'd0, 24'd0}},
        '{OP_START, 8'd0,   8'd0,   8'd0,   PIN_RESULT, '{KIND_DONE,  20'd0,      8'd0, 24'd0}}
    };

    t_geometry plan [8] = '{
        '{1'b0, 7'd35,  20'd174848,  24'd65536,    110, 1'b0},
        '{1'b1, 7'd80,  20'd819200,  24'd16777215, 130, 1'b0},
        '{1'b0, 7'd40,  20'd196608,  24'd300,      100, 1'b0},
        '{1'b1, 7'd127, 20'd1048575, 24'd1,        80,  1'b0},
        '{1'b0, 7'd127, 20'd0,       24'd0,        25,  1'b0},
        '{1'b0, 7'd0,   20'd1048575, 24'd16777215, 25,  1'b0},
        '{1'b1, 7'd1,   20'd10240,   24'd600,      80,  1'b0},
        '{1'b0, 7'd35,  20'd174848,  24'd65536,    170, 1'b1}
    };

    disk_sector_chain_reader #(
        .ZONE_TABLE_TRACKS(ZONE_TRACKS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_opcode(i_opcode),
        .i_start_track(i_start_track),
        .i_start_sector(i_start_sector),
        .i_sector_byte(i_sector_byte),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_result_kind(o_result_kind),
        .o_sector_offset(o_sector_offset),
        .o_data_out(o_data_out),
        .o_loaded_count(o_loaded_count)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit locate_sector(input logic [7:0] trk, input logic [7:0] sec,
                                         output logic [19:0] off);
        int unsigned spt;
        int unsigned base;
        off = '0;
        if (trk == 0 || trk > geo_max_trk) return 0;
        if (geo_d81) begin
            spt = D81_SPT;
            base = (trk - 1) * D81_SPT;
        end else begin
            if (trk > ZONE_TRACKS) return 0;
            if (trk <= D64_ZONE1_LAST) begin
                spt = D64_ZONE1_SPT;
                base = (trk - 1) * D64_ZONE1_SPT;
            end else if (trk <= D64_ZONE2_LAST) begin
                spt = D64_ZONE2_SPT;
                base = D64_ZONE2_BASE + (trk - D64_ZONE1_LAST - 1) * D64_ZONE2_SPT;
            end else if (trk <= D64_ZONE3_LAST) begin
                spt = D64_ZONE3_SPT;
                base = D64_ZONE3_BASE + (trk - D64_ZONE2_LAST - 1) * D64_ZONE3_SPT;
            end else begin
                spt = D64_ZONE4_SPT;
                base = D64_ZONE4_BASE + (trk - D64_ZONE3_LAST - 1) * D64_ZONE4_SPT;
            end
        end
        if (sec >= spt) return 0;
        if ((base + sec) * SEC_BYTES + SEC_BYTES > geo_size) return 0;
        off = 20'((base + sec) * SEC_BYTES);
        return 1;
    endfunction

    function automatic bit walk_chain(input logic op, input logic [7:0] trk,
                                      input logic [7:0] sec, input logic [7:0] byt,
                                      output t_chain_result r);
        logic [19:0] off;
        logic [7:0]  pos;
        int unsigned span;
        bit          got;
        r = NO_WANT;
        got = 1;
        if (op == OP_START) begin
            walking = 0;
            walk_pos = 0;
            walk_count = 0;
            if (geo_cap == 0) begin
                r.kind = KIND_ERROR;
            end else if (trk == 0) begin
                r.kind = KIND_DONE;
            end else if (!locate_sector(trk, sec, off)) begin
                r.kind = KIND_ERROR;
            end else begin
                walking = 1;
                r.off = off;
            end
        end else if (!walking) begin
            got = 0;
        end else begin
            pos = walk_pos;
            walk_pos = pos + 8'd1;
            if (pos == 0) begin
                walk_link_trk = byt;
                got = 0;
            end else if (pos == 1) begin
                walk_link_sec = byt;
                span = (walk_link_trk == 0) ? byt - 1 : SEC_BYTES - 2;
                if (walk_link_trk == 0 && byt <= 1) begin
                    walking = 0;
                    r.kind = KIND_DONE;
                end else if (walk_count + span > geo_cap) begin
                    walking = 0;
                    r.kind = KIND_ERROR;
                end else if (walk_link_trk == 0) begin
                    got = 0;
                end else if (!locate_sector(walk_link_trk, byt, off)) begin
                    walking = 0;
                    r.kind = KIND_ERROR;
                end else begin
                    r.off = off;
                end
            end else if (walk_link_trk != 0 || pos <= walk_link_sec) begin
                walk_count = walk_count + 24'd1;
                r.data = byt;
                if (walk_link_trk == 0 && pos == walk_link_sec) begin
                    walking = 0;
                    r.kind = KIND_DONE;
                end else begin
                    r.kind = KIND_DATA;
                end
            end else begin
                walking = 0;
                got = 0;
            end
        end
        r.cnt = walk_count;
        return got;
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        if (faults < 100)
            $display("mismatch at %0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
        faults++;
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_chain_result r;
        t_chain_result want;
        bit            got;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                got = walk_chain(i_opcode, i_start_track, i_start_sector, i_sector_byte, r);
                if (pin_mode == PIN_RESULT) due_results.push_back(pin_want);
                else if (pin_mode == PIN_FREE && got) due_results.push_back(r);
            end
            if (o_out_valid && !i_out_stall) begin
                results_checked++;
                if (due_results.size() == 0) begin
                    report_mismatch("result with nothing due, kind", 0, o_result_kind);
                end else begin
                    want = due_results.pop_front();
                    if (o_result_kind !== want.kind)
                        report_mismatch("result_kind", want.kind, o_result_kind);
                    if (o_sector_offset !== want.off)
                        report_mismatch("sector_offset", want.off, o_sector_offset);
                    if (o_data_out !== want.data)
                        report_mismatch("data_out", want.data, o_data_out);
                    if (o_loaded_count !== want.cnt)
                        report_mismatch("loaded_count", want.cnt, o_loaded_count);
                end
            end
        end
    end

    always @(posedge i_clk)
        i_out_stall <= !calm && ($urandom_range(99) < 37);

    task automatic send_row(input t_stim_row row);
        while (!calm && $urandom_range(99) < 37) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= row.op;
        i_start_track <= row.trk;
        i_start_sector <= row.sec;
        i_sector_byte <= row.byt;
        pin_mode <= row.pin;
        pin_want <= row.want;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        work_items++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (due_results.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic apply_geometry(input t_geometry g);
        write_reg(REG_IMAGE_IS_D81, 24'(g.d81));
        write_reg(REG_TRACK_LIMIT, 24'(g.max_trk));
        write_reg(REG_IMAGE_SIZE, 24'(g.size));
        write_reg(REG_OUT_CAPACITY, g.cap);
        i_cfg_we <= 1'b0;
        geo_d81 = g.d81;
        geo_max_trk = g.max_trk;
        geo_size = g.size;
        geo_cap = g.cap;
    endtask

    task automatic pick_sector(output logic [7:0] trk, output logic [7:0] sec);
        logic [19:0] spot;
        for (int n = 0; n < 32; n++) begin
            trk = 8'($urandom_range(1, geo_d81 ? 80 : ZONE_TRACKS));
            sec = 8'($urandom_range(0, geo_d81 ? D81_SPT - 1 : D64_ZONE1_SPT - 1));
            if (locate_sector(trk, sec, spot)) return;
        end
        trk = 8'($urandom);
        sec = 8'($urandom);
    endtask

    task automatic run_chain();
        t_stim_row  row;
        logic [7:0] lt;
        logic [7:0] ls;
        int         hops;
        int         last;
        int         sent;
        int         cut;
        row.pin = PIN_FREE;
        row.want = NO_WANT;
        row.trk = 8'($urandom);
        row.sec = 8'($urandom);
        row.byt = 8'($urandom);
        if ($urandom_range(99) < 6) begin
            repeat ($urandom_range(1, 4)) begin
                row.op = 1'($urandom_range(1));
                row.trk = 8'($urandom);
                row.sec = 8'($urandom);
                row.byt = 8'($urandom);
                send_row(row);
            end
            return;
        end
        row.op = OP_START;
        if ($urandom_range(99) < 85) pick_sector(row.trk, row.sec);
        send_row(row);
        row.op = OP_BYTE;
        hops = ($urandom_range(99) < 12) ? $urandom_range(1, 2) : 0;
        cut = ($urandom_range(99) < 5) ? $urandom_range(1, 300) : -1;
        sent = 0;
        for (int h = 0; h <= hops; h++) begin
            if (h < hops) begin
                if ($urandom_range(99) < 90) begin
                    pick_sector(lt, ls);
                end else begin
                    lt = 8'($urandom_range(1, 255));
                    ls = 8'($urandom);
                end
                last = 255;
            end else begin
                lt = 8'd0;
                ls = 8'(($urandom_range(99) < 70) ? $urandom_range(0, 20) : $urandom);
                last = ls + (($urandom_range(99) < 20) ? $urandom_range(1, 3) : 0);
                if (last > 255) last = 255;
            end
            for (int p = 0; p <= last; p++) begin
                row.byt = (p == 0) ? lt : (p == 1) ? ls : 8'($urandom);
                send_row(row);
                sent++;
                if (sent == cut || work_items >= item_goal) return;
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (script[i]) send_row(script[i]);
        foreach (plan[p]) begin
            settle();
            apply_geometry(plan[p]);
            calm = plan[p].quiet;
            item_goal = work_items + plan[p].quota;
            while (work_items < item_goal) run_chain();
        end
        settle();
        $display("chain walks: %0d requests sent, %0d results checked, %0d geometry settings",
                 work_items, results_checked, $size(plan) + 1);
        if (faults == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d field mismatches", faults);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results still due", due_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
